// ----- hdl/base64_codec_core_assert.svh -----
// assertion macros for the base64 codec core
// used by the port checker; no other dependencies
`ifndef BASE64_CODEC_CORE_ASSERT_SVH
`define BASE64_CODEC_CORE_ASSERT_SVH

// same-cycle implication, quiet while reset is high
`define B64C_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, quiet while reset is high
`define B64C_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/b64c_pkg.sv -----
// shared types, constants and alphabet lookups for the base64 codec core
// no dependencies
`default_nettype none

package b64c_pkg;

   localparam logic [7:0] PAD_CHAR    = 8'h3D;
   localparam logic [2:0] ENC_RESULTS = 3'd4;

   // results of one accepted item, handed from the group logic to the output stage
   typedef struct packed {
      logic            load;
      logic [2:0]      count;
      logic [3:0][7:0] data;   // data[0] goes out first
   } burst_type;

   // 6-bit value to alphabet character
   function automatic logic [7:0] enc_char(input logic [5:0] v);
      logic [7:0] c;
      c = 8'h00;
      if (v < 6'd26)      c = 8'h41 + {2'b00, v};
      else if (v < 6'd52) c = 8'h61 + {2'b00, v - 6'd26};
      else if (v < 6'd62) c = 8'h30 + {2'b00, v - 6'd52};
      else if (v == 6'd62) c = 8'h2B;
      else                c = 8'h2F;
      return c;
   endfunction

   // alphabet character to 6-bit value, anything else gives zero
   function automatic logic [5:0] dec_value(input logic [7:0] c);
      logic [5:0] v;
      v = 6'd0;
      if (c inside {[8'h41:8'h5A]})      v = 6'(c - 8'h41);
      else if (c inside {[8'h61:8'h7A]}) v = 6'(c - 8'h61 + 8'd26);
      else if (c inside {[8'h30:8'h39]}) v = 6'(c - 8'h30 + 8'd52);
      else if (c == 8'h2B)               v = 6'd62;
      else if (c == 8'h2F)               v = 6'd63;
      return v;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/b64c_group.sv -----
// group gathering for the base64 codec: mode register, group state and the
// single-pass encode/decode logic; uses b64c_pkg
`default_nettype none

module b64c_group (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_write,
   input  wire logic                 csr_mode,
   input  wire logic                 item_accept,
   input  wire logic [7:0]           item_value,
   input  wire logic                 item_last,
   output b64c_pkg::burst_type       burst
);

   localparam logic [2:0] ENC_COUNT = b64c_pkg::ENC_RESULTS;

   logic        mode_ff, mode_in;
   logic [23:0] bits_ff, bits_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic [1:0]  pad_ff, pad_in;

   logic [1:0]  enc_pos;
   logic [2:0]  enc_held;
   logic [23:0] enc_bits;
   logic [23:0] dec_bits;
   logic [5:0]  dec_val;
   logic        is_pad;
   logic [1:0]  pad_next;
   logic [2:0]  pads_sum;
   logic [1:0]  pads;
   logic [1:0]  dec_n;
   logic        emit;

   always_comb begin
      // encode side
      enc_pos  = (cnt_ff == 2'd3) ? 2'd2 : cnt_ff;
      enc_held = {1'b0, enc_pos} + 3'd1;
      case (enc_pos)
         2'd0:    enc_bits = bits_ff | {item_value, 16'h0000};
         2'd1:    enc_bits = bits_ff | {8'h00, item_value, 8'h00};
         default: enc_bits = bits_ff | {16'h0000, item_value};
      endcase

      // decode side
      is_pad   = (item_value == b64c_pkg::PAD_CHAR);
      pad_next = (is_pad && pad_ff != 2'd3) ? pad_ff + 2'd1 : pad_ff;
      dec_val  = is_pad ? 6'd0 : b64c_pkg::dec_value(item_value);
      case (cnt_ff)
         2'd0:    dec_bits = bits_ff | {dec_val, 18'h00000};
         2'd1:    dec_bits = bits_ff | {6'h00, dec_val, 12'h000};
         2'd2:    dec_bits = bits_ff | {12'h000, dec_val, 6'h00};
         default: dec_bits = bits_ff | {18'h00000, dec_val};
      endcase
      // missing characters of a short final group count as padding
      pads_sum = {1'b0, pad_next} + (3'd3 - {1'b0, cnt_ff});
      pads     = (pads_sum > 3'd3) ? 2'd3 : pads_sum[1:0];
      dec_n    = 2'd3 - pads;

      burst.load  = 1'b0;
      burst.count = ENC_COUNT;
      burst.data  = '0;
      if (mode_ff) begin
         emit        = (cnt_ff == 2'd3) || item_last;
         burst.count = {1'b0, dec_n};
         burst.data  = {8'h00, dec_bits[7:0], dec_bits[15:8], dec_bits[23:16]};
      end else begin
         emit = (enc_held == 3'd3) || item_last;
         for (int k = 0; k < 4; k++) begin
            if (3'(k) <= enc_held) begin
               burst.data[k] = b64c_pkg::enc_char(enc_bits[23 - 6 * k -: 6]);
            end else begin
               burst.data[k] = b64c_pkg::PAD_CHAR;
            end
         end
      end
      burst.load = item_accept && emit && (burst.count != 3'd0);

      mode_in = mode_ff;
      bits_in = bits_ff;
      cnt_in  = cnt_ff;
      pad_in  = pad_ff;
      if (csr_write) begin
         mode_in = csr_mode;
         bits_in = '0;
         cnt_in  = '0;
         pad_in  = '0;
      end else if (item_accept) begin
         if (emit) begin
            bits_in = '0;
            cnt_in  = '0;
            pad_in  = '0;
         end else if (mode_ff) begin
            bits_in = dec_bits;
            cnt_in  = cnt_ff + 2'd1;
            pad_in  = pad_next;
         end else begin
            bits_in = enc_bits;
            cnt_in  = enc_held[1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         bits_ff <= '0;
         cnt_ff  <= '0;
         pad_ff  <= '0;
      end else begin
         mode_ff <= mode_in;
         bits_ff <= bits_in;
         cnt_ff  <= cnt_in;
         pad_ff  <= pad_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/b64c_burst.sv -----
// result registers for the base64 codec: one set of up to four result bytes
// sent one beat at a time, plus one set held behind it; uses b64c_pkg
`default_nettype none

module b64c_burst (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire b64c_pkg::burst_type  burst,
   output logic                      free,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [7:0]                rsp_tdata,
   output logic                      rsp_tlast
);

   logic [2:0]      cnt_ff, cnt_in;
   logic [3:0][7:0] data_ff, data_in;
   logic            held_ff, held_in;
   logic [2:0]      held_cnt_ff, held_cnt_in;
   logic [3:0][7:0] held_data_ff, held_data_in;
   logic            take;
   logic            drain;

   assign rsp_tvalid = (cnt_ff != 3'd0);
   assign rsp_tdata  = data_ff[0];
   assign rsp_tlast  = (cnt_ff == 3'd1);
   assign take       = rsp_tvalid && rsp_tready;
   // sending set empty, or its final beat leaves this cycle
   assign drain      = (cnt_ff == 3'd0) || (rsp_tlast && rsp_tready);
   // input waits only while a second set is held
   assign free       = !held_ff;

   always_comb begin
      cnt_in       = cnt_ff;
      data_in      = data_ff;
      held_in      = held_ff;
      held_cnt_in  = held_cnt_ff;
      held_data_in = held_data_ff;
      if (take) begin
         cnt_in  = cnt_ff - 3'd1;
         data_in = {8'h00, data_ff[3:1]};
      end
      if (drain) begin
         if (held_ff) begin
            cnt_in  = held_cnt_ff;
            data_in = held_data_ff;
            held_in = 1'b0;
         end else if (burst.load) begin
            cnt_in  = burst.count;
            data_in = burst.data;
         end
      end else if (burst.load) begin
         held_in      = 1'b1;
         held_cnt_in  = burst.count;
         held_data_in = burst.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         held_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         held_ff <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff      <= data_in;
      held_cnt_ff  <= held_cnt_in;
      held_data_ff <= held_data_in;
   end

endmodule

`default_nettype wire

// ----- hdl/base64_codec_core.sv -----
// latency: results of an item appear the cycle after it is accepted, or once the beats ahead
//   of them have gone
// throughput: one item per cycle; a completed group waits in a holding set while the one ahead
//   drains, and req_tready is low only while that set is held, so encode is held back by its
//   output (4 beats per group) and decode keeps one item per cycle while rsp_tready stays high
// reset: synchronous, active high; encode mode, empty group, no result pending
// top level of the base64 codec; uses b64c_pkg, b64c_group and b64c_burst
`default_nettype none

module base64_codec_core (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic       csr_data,     // decode_mode
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,    // in_value
   input  wire logic       req_tlast,    // in_last
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,    // out_value
   output logic            rsp_tlast     // out_last
);

   b64c_pkg::burst_type burst;
   logic                free;

   assign csr_ready  = 1'b1;
   assign req_tready = free;

   b64c_group u_group (
      .clock       (clock),
      .reset       (reset),
      .csr_write   (csr_valid && csr_ready),
      .csr_mode    (csr_data),
      .item_accept (req_tvalid && req_tready),
      .item_value  (req_tdata),
      .item_last   (req_tlast),
      .burst       (burst)
   );

   b64c_burst u_burst (
      .clock      (clock),
      .reset      (reset),
      .burst      (burst),
      .free       (free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

// ----- hdl/b64c_checker.sv -----
// port checker for base64_codec_core, attached by bind
// uses the macros of base64_codec_core_assert.svh
`default_nettype none

`include "base64_codec_core_assert.svh"

module b64c_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_tready,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata,
   input wire logic       rsp_tlast
);

   // stalled result beat holds
   `B64C_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "stalled result beat changed")

   // input only waits behind results still to be sent
   `B64C_ASSERT_NOW(a_req_blocked, !req_tready, rsp_tvalid, "input stalled with no result pending")

   // a group never ends early
   `B64C_ASSERT_NEXT(a_group_cont, rsp_tvalid && rsp_tready && !rsp_tlast, rsp_tvalid, "result group broke off before its last beat")

   // nothing pending straight after reset
   `B64C_ASSERT_NOW(a_reset_empty, $fell(reset), !rsp_tvalid, "result pending after reset")

endmodule

bind base64_codec_core b64c_checker u_chk (.*);

`default_nettype wire

// ----- tb/base64_codec_core_tb.sv -----
// self-checking testbench for base64_codec_core: directed rows, then random messages
// results checked beat by beat against a predictor of the base64 group logic
// depends on b64c_pkg and base64_codec_core only
`default_nettype none

module base64_codec_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic MODE_ENCODE = 1'b0;
   localparam logic MODE_DECODE = 1'b1;
   localparam int   HOLDOFF_CYCLES = 300;

   typedef enum logic [0:0] {ROW_ITEM, ROW_MODE} row_kind_type;

   // one directed row; chars holds typed results, first beat in the top byte
   typedef struct packed {
      row_kind_type kind;
      logic [7:0]   value;
      logic         last;
      logic         typed;
      logic [2:0]   count;
      logic [31:0]  chars;
   } stim_row_type;

   typedef struct packed {
      logic [7:0] value;
      logic       last;
   } beat_type;

   localparam int N_ROWS = 25;
   localparam stim_row_type DIRECTED_ROWS [N_ROWS] = '{
      '{ROW_ITEM, 8'h00, 1'b1, 1'b1, 3'd4, "AA=="},
      '{ROW_ITEM, 8'hFF, 1'b1, 1'b1, 3'd4, "/w=="},
      '{ROW_ITEM, 8'hFF, 1'b0, 1'b1, 3'd0, 32'h0},
      '{ROW_ITEM, 8'hFF, 1'b0, 1'b1, 3'd0, 32'h0},
      '{ROW_ITEM, 8'hFF, 1'b0, 1'b1, 3'd4, "////"},
      '{ROW_ITEM, 8'h4D, 1'b0, 1'b0, 3'd0, 32'h0},
      '{ROW_ITEM, 8'h61, 1'b1, 1'b1, 3'd4, "TWE="},
      // partial group, dropped by the mode write below
      '{ROW_ITEM, 8'h41, 1'b0, 1'b1, 3'd0, 32'h0},
      '{ROW_MODE, {7'd0, MODE_DECODE}, 1'b0, 1'b0, 3'd0, 32'h0},
      '{ROW_ITEM, "/", 1'b0, 1'b1, 3'd0, 32'h0},
      '{ROW_ITEM, "/", 1'b0, 1'b1, 3'd0, 32'h0},
      '{ROW_ITEM, "/", 1'b0, 1'b1, 3'd0, 32'h0},
      '{ROW_ITEM, "/", 1'b0, 1'b1, 3'd3, 32'hFFFFFF00},
      // all padding: the group gives nothing
      '{ROW_ITEM, "=", 1'b0, 1'b1, 3'd0, 32'h0},
      '{ROW_ITEM, "=", 1'b0, 1'b1, 3'd0, 32'h0},
      '{ROW_ITEM, "=", 1'b0, 1'b1, 3'd0, 32'h0},
      '{ROW_ITEM, "=", 1'b0, 1'b1, 3'd0, 32'h0},
      // characters outside the alphabet decode as zero
      '{ROW_ITEM, 8'h00, 1'b0, 1'b1, 3'd0, 32'h0},
      '{ROW_ITEM, 8'hFF, 1'b0, 1'b1, 3'd0, 32'h0},
      '{ROW_ITEM, "*", 1'b0, 1'b1, 3'd0, 32'h0},
      '{ROW_ITEM, "=", 1'b1, 1'b1, 3'd2, 32'h0},
      // short final groups, unpadded
      '{ROW_ITEM, "T", 1'b0, 1'b1, 3'd0, 32'h0},
      '{ROW_ITEM, "W", 1'b1, 1'b1, 3'd1, 32'h4D000000},
      '{ROW_ITEM, "A", 1'b1, 1'b1, 3'd0, 32'h0},
      '{ROW_MODE, {7'd0, MODE_ENCODE}, 1'b0, 1'b0, 3'd0, 32'h0}
   };

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic       csr_data = 1'b0;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;   // in_value
   logic       req_tlast = 1'b0;    // in_last
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // out_value
   logic       rsp_tlast;           // out_last

   base64_codec_core uut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #2ns clock = ~clock;

   string b64_letters =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   // predictor state
   logic        mode_dec = MODE_ENCODE;
   logic [23:0] grp = 24'd0;
   logic [1:0]  grp_cnt = 2'd0;
   logic [1:0]  eq_cnt = 2'd0;

   beat_type owed_beats [$];
   int    mismatches = 0;
   int    idle_pct = 0;
   int    stall_pct = 0;
   int    items_sent = 0;
   int    holdoff_asked = 0;
   int    holdoff_seen = 0;
   int    holdoff_left = 0;

   task automatic flag_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatches++;
   endtask

   function automatic logic [5:0] char_sextet(input logic [7:0] c);
      for (int k = 0; k < 64; k++)
         if (b64_letters[k] == c) return 6'(k);
      return 6'd0;
   endfunction

   task automatic clear_group();
      grp = 24'd0;
      grp_cnt = 2'd0;
      eq_cnt = 2'd0;
   endtask

   // works out the beats one accepted item gives, oldest first
   task automatic code_item(input logic [7:0] v, input logic l,
                            output logic [3:0][7:0] res, output int n);
      int pos, held, pads;
      logic [5:0] sx;
      n = 0;
      res = '0;
      if (mode_dec == MODE_ENCODE) begin
         pos = (grp_cnt > 2'd2) ? 2 : int'(grp_cnt);
         grp = grp | (24'(v) << (16 - 8 * pos));
         held = pos + 1;
         grp_cnt = 2'(held);
         if (held == 3 || l) begin
            for (int k = 0; k < 4; k++)
               res[k] = (k <= held) ? b64_letters[grp[18 - 6 * k +: 6]] : b64c_pkg::PAD_CHAR;
            n = 4;
            clear_group();
         end
      end else begin
         pos = int'(grp_cnt);
         sx = 6'd0;
         if (v == b64c_pkg::PAD_CHAR) begin
            if (eq_cnt != 2'd3) eq_cnt = eq_cnt + 2'd1;
         end else begin
            sx = char_sextet(v);
         end
         grp = grp | (24'(sx) << (18 - 6 * pos));
         held = pos + 1;
         grp_cnt = 2'(held);
         if (held == 4 || l) begin
            // missing characters of a short final group count as padding
            pads = int'(eq_cnt) + 4 - held;
            if (pads > 3) pads = 3;
            n = 3 - pads;
            for (int k = 0; k < n; k++) res[k] = grp[16 - 8 * k +: 8];
            clear_group();
         end
      end
   endtask

   task automatic offer_item(input logic [7:0] v, input logic l, input logic typed,
                             input logic [2:0] count, input logic [31:0] chars);
      int gap, n;
      logic [3:0][7:0] predicted;
      beat_type beat;
      gap = 0;
      while (gap < 60 && $urandom_range(99) < idle_pct) gap++;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= v;
      req_tlast  <= l;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      code_item(v, l, predicted, n);
      if (typed) n = int'(count);
      for (int k = 0; k < n; k++) begin
         beat.value = typed ? chars[31 - 8 * k -: 8] : predicted[k];
         beat.last  = (k == n - 1);
         owed_beats.push_back(beat);
      end
   endtask

   // lets every owed beat arrive, then waits on for items that gave none
   task automatic settle();
      req_tvalid <= 1'b0;
      while (owed_beats.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_mode(input logic m);
      settle();
      csr_valid <= 1'b1;
      csr_data  <= m;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      mode_dec = m;
      clear_group();
   endtask

   task automatic random_message();
      int len, total, r;
      logic [7:0] ch;
      logic wellformed, keep_last;
      keep_last = ($urandom_range(7) != 0);
      if (mode_dec == MODE_ENCODE) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 7);
         for (int k = 0; k < len; k++)
            offer_item(8'($urandom_range(255)), keep_last && k == len - 1, 1'b0, 3'd0, 32'h0);
      end else begin
         wellformed = ($urandom_range(9) < 7);
         len = $urandom_range(1, 12);
         total = len;
         if (wellformed && $urandom_range(1) == 1 && len % 4 > 1) total = len + 4 - len % 4;
         for (int k = 0; k < total; k++) begin
            r = $urandom_range(99);
            if (k >= len) ch = b64c_pkg::PAD_CHAR;
            else if (wellformed || r < 78) ch = b64_letters[$urandom_range(63)];
            else if (r < 86) ch = b64c_pkg::PAD_CHAR;
            else ch = 8'($urandom_range(255));
            offer_item(ch, keep_last && k == total - 1, 1'b0, 3'd0, 32'h0);
         end
      end
   endtask

   task automatic run_phase(input int idle, input int stall, input int quota, input logic squeeze);
      int goal;
      idle_pct = idle;
      stall_pct = stall;
      goal = items_sent + quota;
      if (squeeze) begin
         // long receiver hold-off while a long message keeps coming
         write_mode(MODE_ENCODE);
         holdoff_asked <= holdoff_asked + 1;
         for (int k = 0; k < 30; k++)
            offer_item(8'($urandom_range(255)), k == 29, 1'b0, 3'd0, 32'h0);
      end
      while (items_sent < goal) begin
         if ($urandom_range(2) == 0) write_mode(1'($urandom_range(1)));
         random_message();
      end
   endtask

   // receiver side
   always @(posedge clock) begin
      if (holdoff_seen != holdoff_asked) begin
         holdoff_seen <= holdoff_asked;
         holdoff_left <= HOLDOFF_CYCLES;
         rsp_tready   <= 1'b0;
      end else if (holdoff_left != 0) begin
         holdoff_left <= holdoff_left - 1;
         rsp_tready   <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin : watch_rsp
      beat_type head;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (owed_beats.size() == 0) begin
            flag_mismatch($sformatf("beat %h last %b with nothing owed", rsp_tdata, rsp_tlast));
         end else begin
            head = owed_beats.pop_front();
            if (rsp_tdata !== head.value)
               flag_mismatch($sformatf("value %h, predicted %h", rsp_tdata, head.value));
            if (rsp_tlast !== head.last)
               flag_mismatch($sformatf("last %b, predicted %b", rsp_tlast, head.last));
         end
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < N_ROWS; i++) begin
         if (DIRECTED_ROWS[i].kind == ROW_MODE)
            write_mode(DIRECTED_ROWS[i].value[0]);
         else
            offer_item(DIRECTED_ROWS[i].value, DIRECTED_ROWS[i].last, DIRECTED_ROWS[i].typed,
                       DIRECTED_ROWS[i].count, DIRECTED_ROWS[i].chars);
      end
      run_phase(0, 0, 32, 1'b1);
      run_phase(84, 0, 32, 1'b0);
      run_phase(0, 84, 32, 1'b0);
      run_phase(24, 24, 32, 1'b0);
      settle();
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      #2ms;
      $display("Some tests failed");
      $finish;
   end

endmodule

`default_nettype wire
